FILE: rtl/xmd_pkg.sv
// Shared types and constants for the 8086 MOV decoder.
`timescale 1ns / 1ps
package xmd_pkg;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_MODRM,
    PH_LOW,
    PH_HIGH
  } xmd_phase_t;

  localparam logic [5:0] OP_MOV_RM  = 6'b100010;
  localparam logic [3:0] OP_MOV_IMM = 4'b1011;
  localparam logic [2:0] RM_DIRECT  = 3'b110;
  localparam logic [2:0] RM_BX      = 3'b111;

  localparam logic [1:0] MOD_MEM    = 2'b00;
  localparam logic [1:0] MOD_DISP8  = 2'b01;
  localparam logic [1:0] MOD_DISP16 = 2'b10;
  localparam logic [1:0] MOD_REG    = 2'b11;

  localparam logic [1:0] KIND_REG    = 2'd0;
  localparam logic [1:0] KIND_EA     = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;
  localparam logic [1:0] KIND_IMM    = 2'd3;

  typedef struct packed {
    logic        unknown;
    logic [7:0]  opcode;
    logic [7:0]  modrm;
    logic [15:0] value;
    logic [2:0]  len;
  } xmd_rec_t;

  typedef struct packed {
    logic     push;
    xmd_rec_t rec;
  } xmd_push_t;

  typedef struct packed {
    logic        is_unknown;
    logic        wide;
    logic [1:0]  dst_kind;
    logic [3:0]  dst_register;
    logic [1:0]  src_kind;
    logic [3:0]  src_register;
    logic [2:0]  address_form;
    logic [15:0] displacement;
    logic [15:0] operand_value;
    logic [2:0]  length;
  } xmd_out_t;

endpackage

FILE: rtl/xmd_front.sv
// Byte collector: gathers opcode, ModRM and extra bytes into one instruction record.
`timescale 1ns / 1ps
module xmd_front
  import xmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] code_byte,
  output xmd_push_t  push_out
);

  xmd_phase_t phase, phase_next;
  logic [7:0] opcode_held, opcode_held_next;
  logic [7:0] modrm_held, modrm_held_next;
  logic [7:0] low_byte_held, low_byte_held_next;
  logic [1:0] bytes_left, bytes_left_next;
  logic [2:0] bytes_taken, bytes_taken_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_OPCODE;
      opcode_held   <= '0;
      modrm_held    <= '0;
      low_byte_held <= '0;
      bytes_left    <= '0;
      bytes_taken   <= '0;
    end else begin
      phase         <= phase_next;
      opcode_held   <= opcode_held_next;
      modrm_held    <= modrm_held_next;
      low_byte_held <= low_byte_held_next;
      bytes_left    <= bytes_left_next;
      bytes_taken   <= bytes_taken_next;
    end
  end

  always_comb begin
    logic [1:0] extra;
    logic [1:0] left_dec;
    logic [2:0] taken_inc;
    extra              = 2'd0;
    left_dec           = bytes_left - 2'd1;
    taken_inc          = bytes_taken + 3'd1;
    phase_next         = phase;
    opcode_held_next   = opcode_held;
    modrm_held_next    = modrm_held;
    low_byte_held_next = low_byte_held;
    bytes_left_next    = bytes_left;
    bytes_taken_next   = bytes_taken;
    push_out           = '0;
    if (accept) begin
      unique case (phase)
        PH_MODRM: begin
          modrm_held_next  = code_byte;
          bytes_taken_next = 3'd2;
          unique case (code_byte[7:6])
            MOD_DISP8:  extra = 2'd1;
            MOD_DISP16: extra = 2'd2;
            MOD_MEM:    extra = (code_byte[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            default:    extra = 2'd0;
          endcase
          if (extra == 2'd0) begin
            push_out.push        = 1'b1;
            push_out.rec.opcode  = opcode_held;
            push_out.rec.modrm   = code_byte;
            push_out.rec.len     = 3'd2;
            phase_next           = PH_OPCODE;
            bytes_left_next      = 2'd0;
          end else begin
            bytes_left_next = extra;
            phase_next      = PH_LOW;
          end
        end
        PH_LOW: begin
          low_byte_held_next = code_byte;
          bytes_taken_next   = taken_inc;
          bytes_left_next    = left_dec;
          if (left_dec == 2'd0) begin
            push_out.push       = 1'b1;
            push_out.rec.opcode = opcode_held;
            push_out.rec.modrm  = modrm_held;
            push_out.rec.value  = {8'h00, code_byte};
            push_out.rec.len    = taken_inc;
            phase_next          = PH_OPCODE;
          end else begin
            phase_next = PH_HIGH;
          end
        end
        PH_HIGH: begin
          bytes_taken_next    = taken_inc;
          bytes_left_next     = 2'd0;
          push_out.push       = 1'b1;
          push_out.rec.opcode = opcode_held;
          push_out.rec.modrm  = modrm_held;
          push_out.rec.value  = {code_byte, low_byte_held};
          push_out.rec.len    = taken_inc;
          phase_next          = PH_OPCODE;
        end
        default: begin
          phase_next = PH_OPCODE;
          if (code_byte[7:2] == OP_MOV_RM) begin
            opcode_held_next = code_byte;
            bytes_taken_next = 3'd1;
            bytes_left_next  = 2'd0;
            phase_next       = PH_MODRM;
          end else if (code_byte[7:4] == OP_MOV_IMM) begin
            opcode_held_next = code_byte;
            bytes_taken_next = 3'd1;
            bytes_left_next  = code_byte[3] ? 2'd2 : 2'd1;
            phase_next       = PH_LOW;
          end else begin
            bytes_taken_next     = 3'd0;
            bytes_left_next      = 2'd0;
            push_out.push        = 1'b1;
            push_out.rec.unknown = 1'b1;
            push_out.rec.len     = 3'd1;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/xmd_queue.sv
// Two-entry queue of collected instruction records between front and back.
`timescale 1ns / 1ps
module xmd_queue
  import xmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  xmd_push_t push_in,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output xmd_rec_t  head
);

  xmd_rec_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      entries[wr_ptr] <= push_in.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_in.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/xmd_back.sv
// Field decoder and output register for one collected MOV instruction.
`timescale 1ns / 1ps
module xmd_back
  import xmd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     head_valid,
  input  xmd_rec_t head,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_ready,
  output xmd_out_t result
);

  xmd_out_t dec;

  assign pop = head_valid && (!result_valid || result_ready);

  always_comb begin
    logic       w;
    logic       d;
    logic [1:0] md;
    logic [2:0] rm;
    logic [1:0] okind;
    logic [3:0] oreg;
    dec   = '0;
    w     = head.opcode[0];
    d     = head.opcode[1];
    md    = head.modrm[7:6];
    rm    = head.modrm[2:0];
    okind = KIND_REG;
    oreg  = 4'd0;
    dec.length = head.len;
    if (head.unknown) begin
      dec.is_unknown = 1'b1;
    end else if (head.opcode[7:4] == OP_MOV_IMM) begin
      dec.wide          = head.opcode[3];
      dec.dst_kind      = KIND_REG;
      dec.dst_register  = {head.opcode[3], head.opcode[2:0]};
      dec.src_kind      = KIND_IMM;
      dec.operand_value = head.value;
    end else begin
      dec.wide = w;
      if (md == MOD_REG) begin
        okind = KIND_REG;
        oreg  = {w, rm};
      end else if (md == MOD_MEM && rm == RM_DIRECT) begin
        okind             = KIND_DIRECT;
        dec.operand_value = head.value;
      end else begin
        okind            = KIND_EA;
        dec.address_form = rm;
        if (md == MOD_DISP8) begin
          dec.displacement = {{8{head.value[7]}}, head.value[7:0]};
        end else if (md == MOD_DISP16) begin
          dec.displacement = head.value;
        end
      end
      if (d) begin
        dec.dst_kind     = KIND_REG;
        dec.dst_register = {w, head.modrm[5:3]};
        dec.src_kind     = okind;
        dec.src_register = oreg;
      end else begin
        dec.dst_kind     = okind;
        dec.dst_register = oreg;
        dec.src_kind     = KIND_REG;
        dec.src_register = {w, head.modrm[5:3]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= dec;
    end
  end

endmodule

FILE: rtl/x86_16_mov_decoder.sv
// Top level of the streaming 8086 MOV decoder.
// Usage:
//   Input channel: one instruction byte per beat on code_byte, code_valid/code_ready.
//   Output channel: one decoded instruction per beat, result_valid/result_ready.
//   A beat that completes an instruction (last extra byte, a ModRM with no extra
//   bytes, or a byte that starts no MOV form) produces exactly one result.
//   The edge that takes the completing byte writes the record queue; the record then
//   loads the output register once that register is empty or being drained.
//   Throughput: one byte per cycle while code_ready is high; set by the single-byte
//   collector in the front. The front and the output register are parted by a two-entry
//   record queue, so with the receiver stalled up to three results are held;
//   code_ready drops only while that queue is full.
//   Reset (synchronous, active high) returns the collector to waiting for an
//   opcode, empties the queue and drops result_valid.
`timescale 1ns / 1ps
module x86_16_mov_decoder
  import xmd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               code_valid,
  output logic               code_ready,
  input  logic [7:0]         code_byte,
  output logic               result_valid,
  input  logic               result_ready,
  output logic               is_unknown,
  output logic               wide,
  output logic [1:0]         dst_kind,
  output logic [3:0]         dst_register,
  output logic [1:0]         src_kind,
  output logic [3:0]         src_register,
  output logic [2:0]         address_form,
  output logic signed [15:0] displacement,
  output logic [15:0]        operand_value,
  output logic [2:0]         length
);

  xmd_push_t push_bus;
  xmd_rec_t  head;
  xmd_out_t  result;
  logic      full;
  logic      head_valid;
  logic      pop;

  assign code_ready = !full;

  xmd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (code_valid && code_ready),
    .code_byte (code_byte),
    .push_out  (push_bus)
  );

  xmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_in    (push_bus),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  xmd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  assign is_unknown    = result.is_unknown;
  assign wide          = result.wide;
  assign dst_kind      = result.dst_kind;
  assign dst_register  = result.dst_register;
  assign src_kind      = result.src_kind;
  assign src_register  = result.src_register;
  assign address_form  = result.address_form;
  assign displacement  = result.displacement;
  assign operand_value = result.operand_value;
  assign length        = result.length;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the 8086 MOV decoder: directed byte rows, then random byte streams.
`timescale 1ns / 1ps
module tb_top;
  import xmd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 650;
  localparam int SEND_IDLE [3] = '{18, 71, 0};
  localparam int RECV_IDLE [3] = '{71, 18, 0};

  typedef struct packed {
    logic [7:0] code;
    logic       fixed;
    xmd_out_t   want;
  } code_beat_t;

  localparam xmd_out_t NO_MOV = '0;
  localparam xmd_out_t BAD_OP = '{is_unknown: 1'b1, length: 3'd1, default: '0};
  localparam xmd_out_t MOV_AL_FF = '{dst_kind: KIND_REG, src_kind: KIND_IMM,
                                     operand_value: 16'h00FF, length: 3'd2, default: '0};
  localparam xmd_out_t MOV_DI_FFFF = '{wide: 1'b1, dst_kind: KIND_REG, dst_register: 4'd15,
                                       src_kind: KIND_IMM, operand_value: 16'hFFFF,
                                       length: 3'd3, default: '0};
  localparam xmd_out_t MOV_AX_DIRECT = '{wide: 1'b1, dst_kind: KIND_REG, dst_register: 4'd8,
                                         src_kind: KIND_DIRECT, operand_value: 16'h1234,
                                         length: 3'd4, default: '0};

  localparam code_beat_t DIRECTED [23] = '{
    '{8'h00, 1'b1, BAD_OP},
    '{8'hFF, 1'b1, BAD_OP},
    '{8'h8C, 1'b1, BAD_OP},
    '{8'h89, 1'b0, NO_MOV},
    '{8'hD8, 1'b0, NO_MOV},
    '{8'h88, 1'b0, NO_MOV},
    '{8'h00, 1'b0, NO_MOV},
    '{8'h8B, 1'b0, NO_MOV},
    '{8'h06, 1'b0, NO_MOV},
    '{8'h34, 1'b0, NO_MOV},
    '{8'h12, 1'b1, MOV_AX_DIRECT},
    '{8'h8B, 1'b0, NO_MOV},
    '{8'h47, 1'b0, NO_MOV},
    '{8'h80, 1'b0, NO_MOV},
    '{8'h8A, 1'b0, NO_MOV},
    '{8'h87, 1'b0, NO_MOV},
    '{8'h00, 1'b0, NO_MOV},
    '{8'h80, 1'b0, NO_MOV},
    '{8'hB0, 1'b0, NO_MOV},
    '{8'hFF, 1'b1, MOV_AL_FF},
    '{8'hBF, 1'b0, NO_MOV},
    '{8'hFF, 1'b0, NO_MOV},
    '{8'hFF, 1'b1, MOV_DI_FFFF}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        code_valid = 1'b0;
  logic        code_ready;
  logic [7:0]  code_byte = 8'h00;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        is_unknown;
  logic        wide;
  logic [1:0]  dst_kind;
  logic [3:0]  dst_register;
  logic [1:0]  src_kind;
  logic [3:0]  src_register;
  logic [2:0]  address_form;
  logic signed [15:0] displacement;
  logic [15:0] operand_value;
  logic [2:0]  length;

  code_beat_t byte_stream[$];
  code_beat_t in_flight;
  xmd_out_t   pending_movs[$];
  xmd_out_t   next_mov;
  xmd_out_t   due;
  int         send_idle_pct = 18;
  int         recv_idle_pct = 71;
  int         fail_count = 0;
  int         cycle_count = 0;

  xmd_phase_t dec_phase = PH_OPCODE;
  logic [7:0] held_opcode = '0;
  logic [7:0] held_modrm = '0;
  logic [7:0] held_low = '0;
  logic [1:0] left_bytes = '0;
  logic [2:0] taken_bytes = '0;

  x86_16_mov_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .code_valid    (code_valid),
    .code_ready    (code_ready),
    .code_byte     (code_byte),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .is_unknown    (is_unknown),
    .wide          (wide),
    .dst_kind      (dst_kind),
    .dst_register  (dst_register),
    .src_kind      (src_kind),
    .src_register  (src_register),
    .address_form  (address_form),
    .displacement  (displacement),
    .operand_value (operand_value),
    .length        (length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic xmd_out_t form_mov(input logic [15:0] val, input logic [2:0] len);
    xmd_out_t   r;
    logic       w;
    logic [3:0] reg_code;
    logic [3:0] rm_reg;
    logic [1:0] rm_kind;
    r = NO_MOV;
    r.length = len;
    if (held_opcode[7:4] == OP_MOV_IMM) begin
      r.wide = held_opcode[3];
      r.dst_kind = KIND_REG;
      r.dst_register = {held_opcode[3], held_opcode[2:0]};
      r.src_kind = KIND_IMM;
      r.operand_value = val;
    end else begin
      w = held_opcode[0];
      r.wide = w;
      reg_code = {w, held_modrm[5:3]};
      rm_reg = '0;
      if (held_modrm[7:6] == MOD_REG) begin
        rm_kind = KIND_REG;
        rm_reg = {w, held_modrm[2:0]};
      end else if (held_modrm[7:6] == MOD_MEM && held_modrm[2:0] == RM_DIRECT) begin
        rm_kind = KIND_DIRECT;
        r.operand_value = val;
      end else begin
        rm_kind = KIND_EA;
        r.address_form = held_modrm[2:0];
        if (held_modrm[7:6] == MOD_DISP8)
          r.displacement = {{8{val[7]}}, val[7:0]};
        else if (held_modrm[7:6] == MOD_DISP16)
          r.displacement = val;
      end
      if (held_opcode[1]) begin
        r.dst_kind = KIND_REG;
        r.dst_register = reg_code;
        r.src_kind = rm_kind;
        r.src_register = rm_reg;
      end else begin
        r.dst_kind = rm_kind;
        r.dst_register = rm_reg;
        r.src_kind = KIND_REG;
        r.src_register = reg_code;
      end
    end
    return r;
  endfunction

  function automatic logic decode_step(input logic [7:0] b, output xmd_out_t res);
    logic done;
    done = 1'b0;
    res = NO_MOV;
    case (dec_phase)
      PH_MODRM: begin
        held_modrm = b;
        taken_bytes = 3'd2;
        if (b[7:6] == MOD_DISP8)
          left_bytes = 2'd1;
        else if (b[7:6] == MOD_DISP16 || (b[7:6] == MOD_MEM && b[2:0] == RM_DIRECT))
          left_bytes = 2'd2;
        else
          left_bytes = 2'd0;
        if (left_bytes == 2'd0) begin
          res = form_mov(16'h0000, 3'd2);
          done = 1'b1;
          dec_phase = PH_OPCODE;
        end else begin
          dec_phase = PH_LOW;
        end
      end
      PH_LOW: begin
        held_low = b;
        taken_bytes = taken_bytes + 3'd1;
        left_bytes = left_bytes - 2'd1;
        if (left_bytes == 2'd0) begin
          res = form_mov({8'h00, b}, taken_bytes);
          done = 1'b1;
          dec_phase = PH_OPCODE;
        end else begin
          dec_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        taken_bytes = taken_bytes + 3'd1;
        left_bytes = 2'd0;
        res = form_mov({b, held_low}, taken_bytes);
        done = 1'b1;
        dec_phase = PH_OPCODE;
      end
      default: begin
        dec_phase = PH_OPCODE;
        if (b[7:2] == OP_MOV_RM) begin
          held_opcode = b;
          taken_bytes = 3'd1;
          left_bytes = 2'd0;
          dec_phase = PH_MODRM;
        end else if (b[7:4] == OP_MOV_IMM) begin
          held_opcode = b;
          taken_bytes = 3'd1;
          left_bytes = b[3] ? 2'd2 : 2'd1;
          dec_phase = PH_LOW;
        end else begin
          taken_bytes = 3'd0;
          left_bytes = 2'd0;
          res = BAD_OP;
          done = 1'b1;
        end
      end
    endcase
    return done;
  endfunction

  function automatic void push_code(input logic [7:0] c);
    byte_stream.push_back('{c, 1'b0, NO_MOV});
  endfunction

  // mostly well-formed MOVs with random content; the rest is arbitrary bytes
  function automatic int queue_random_item();
    logic [7:0] opc;
    logic [7:0] mrm;
    int         pick;
    int         extra;
    pick = $urandom_range(99);
    if (pick < 15) begin
      push_code(8'($urandom_range(255)));
      return 1;
    end
    if (pick < 45) begin
      opc = {OP_MOV_IMM, 4'($urandom_range(15))};
      extra = opc[3] ? 2 : 1;
      push_code(opc);
      for (int i = 0; i < extra; i++)
        push_code(8'($urandom_range(255)));
      return 1 + extra;
    end
    opc = {OP_MOV_RM, 2'($urandom_range(3))};
    mrm = 8'($urandom_range(255));
    if (mrm[7:6] == MOD_DISP8)
      extra = 1;
    else if (mrm[7:6] == MOD_DISP16 || (mrm[7:6] == MOD_MEM && mrm[2:0] == RM_DIRECT))
      extra = 2;
    else
      extra = 0;
    push_code(opc);
    push_code(mrm);
    for (int i = 0; i < extra; i++)
      push_code(8'($urandom_range(255)));
    return 2 + extra;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      code_valid <= 1'b0;
      dec_phase = PH_OPCODE;
      held_opcode = '0;
      held_modrm = '0;
      held_low = '0;
      left_bytes = '0;
      taken_bytes = '0;
    end else begin
      if (code_valid && code_ready) begin
        if (decode_step(in_flight.code, next_mov))
          pending_movs.push_back(in_flight.fixed ? in_flight.want : next_mov);
      end
      if (!code_valid || code_ready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = byte_stream.pop_front();
          code_valid <= 1'b1;
          code_byte <= in_flight.code;
        end else begin
          code_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_movs.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual length %0d", $time, length);
          fail_count++;
        end else begin
          due = pending_movs.pop_front();
          check_field("is_unknown", due.is_unknown, is_unknown);
          check_field("wide", due.wide, wide);
          check_field("dst_kind", due.dst_kind, dst_kind);
          check_field("dst_register", due.dst_register, dst_register);
          check_field("src_kind", due.src_kind, src_kind);
          check_field("src_register", due.src_register, src_register);
          check_field("address_form", due.address_form, address_form);
          check_field("displacement", due.displacement, $unsigned(displacement));
          check_field("operand_value", due.operand_value, operand_value);
          check_field("length", due.length, length);
        end
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int queued;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (DIRECTED[i])
      byte_stream.push_back(DIRECTED[i]);
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_idle_pct = RECV_IDLE[p];
      queued = 0;
      while (queued < PHASE_BYTES)
        queued += queue_random_item();
      while (byte_stream.size() != 0 || code_valid)
        @(negedge clk);
    end
    while (pending_movs.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
